### hw/rtl/transient_shaper_top_macros.svh
// ---------------------------------------------------------------------------
// transient shaper assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ---------------------------------------------------------------------------
`ifndef TRANSIENT_SHAPER_TOP_MACROS_SVH
`define TRANSIENT_SHAPER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/ts_pkg.sv
// ---------------------------------------------------------------------------
// ts_pkg
// types, constants and the control program of the transient shaper
// ---------------------------------------------------------------------------
`default_nettype none

package ts_pkg;

	// program step address
	typedef logic [3:0] step_t;

	localparam step_t STEP_WAIT  = 4'd0;
	localparam step_t STEP_DIFF  = 4'd1;
	localparam step_t STEP_MFAST = 4'd2;
	localparam step_t STEP_WFAST = 4'd3;
	localparam step_t STEP_WSLOW = 4'd4;
	localparam step_t STEP_TB    = 4'd5;
	localparam step_t STEP_MATK  = 4'd6;
	localparam step_t STEP_MSUS  = 4'd7;
	localparam step_t STEP_GAIN  = 4'd8;
	localparam step_t STEP_MMIX  = 4'd9;
	localparam step_t STEP_GEFF  = 4'd10;
	localparam step_t STEP_MOUT  = 4'd11;
	localparam step_t STEP_EMIT  = 4'd12;

	// multiplier operand pairs
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_FAST,
		MUL_SLOW,
		MUL_ATK,
		MUL_SUS,
		MUL_MIX,
		MUL_OUT
	} mul_sel_t;

	// sequencing of the step counter
	typedef enum logic [2:0] {
		SEQ_NEXT,
		SEQ_JUMP,
		SEQ_INPUT,
		SEQ_BYPASS,
		SEQ_OUTPUT
	} seq_t;

	// one control word of the program
	typedef struct packed {
		logic     take;
		mul_sel_t mul_sel;
		logic     ld_diff;
		logic     wr_fast;
		logic     wr_slow;
		logic     ld_tb;
		logic     ld_acc;
		logic     ld_gain;
		logic     ld_geff;
		logic     emit;
		seq_t     seq;
		step_t    target;
	} ctrl_t;

	localparam ctrl_t CTRL_NOP = '{
		take: 1'b0, mul_sel: MUL_NONE, ld_diff: 1'b0, wr_fast: 1'b0, wr_slow: 1'b0,
		ld_tb: 1'b0, ld_acc: 1'b0, ld_gain: 1'b0, ld_geff: 1'b0, emit: 1'b0,
		seq: SEQ_NEXT, target: STEP_WAIT
	};

	// register indexes
	localparam logic [2:0] REG_ENABLE  = 3'd0;
	localparam logic [2:0] REG_FAST    = 3'd1;
	localparam logic [2:0] REG_SLOW    = 3'd2;
	localparam logic [2:0] REG_ATTACK  = 3'd3;
	localparam logic [2:0] REG_SUSTAIN = 3'd4;
	localparam logic [2:0] REG_MIX     = 3'd5;

	// fixed-point constants
	localparam logic [24:0] ONE_Q24 = 25'h1000000;
	localparam logic [23:0] FAST_COEF_RESET = 24'd16661112;
	localparam logic [23:0] SLOW_COEF_RESET = 24'd16772847;
	localparam logic [24:0] FAST_NCOEF_RESET = ONE_Q24 - {1'b0, FAST_COEF_RESET};
	localparam logic [24:0] SLOW_NCOEF_RESET = ONE_Q24 - {1'b0, SLOW_COEF_RESET};
	localparam logic signed [49:0] ONE_Q46  = 50'sd70368744177664;
	localparam logic signed [49:0] GAIN_MAX = 50'sd211106232532992;
	localparam logic signed [32:0] ONE_Q31  = 33'sh080000000;
	localparam logic [15:0] MIX_ONE = 16'd32768;
	localparam logic signed [16:0] WEIGHT_MAX = 17'sd32768;
	localparam logic signed [16:0] WEIGHT_MIN = -17'sd32768;

	// the control program
	function automatic ctrl_t ucode(input step_t pc);
		ctrl_t w;
		w = CTRL_NOP;
		case (pc)
			STEP_WAIT: begin
				w.take = 1'b1;
				w.seq  = SEQ_INPUT;
			end
			STEP_DIFF: begin
				w.ld_diff = 1'b1;
				w.seq     = SEQ_BYPASS;
				w.target  = STEP_EMIT;
			end
			STEP_MFAST: begin
				w.mul_sel = MUL_FAST;
			end
			STEP_WFAST: begin
				w.wr_fast = 1'b1;
				w.mul_sel = MUL_SLOW;
			end
			STEP_WSLOW: begin
				w.wr_slow = 1'b1;
			end
			STEP_TB: begin
				w.ld_tb = 1'b1;
			end
			STEP_MATK: begin
				w.mul_sel = MUL_ATK;
			end
			STEP_MSUS: begin
				w.ld_acc  = 1'b1;
				w.mul_sel = MUL_SUS;
			end
			STEP_GAIN: begin
				w.ld_gain = 1'b1;
			end
			STEP_MMIX: begin
				w.mul_sel = MUL_MIX;
			end
			STEP_GEFF: begin
				w.ld_geff = 1'b1;
			end
			STEP_MOUT: begin
				w.mul_sel = MUL_OUT;
			end
			STEP_EMIT: begin
				w.emit   = 1'b1;
				w.seq    = SEQ_OUTPUT;
				w.target = STEP_WAIT;
			end
			default: begin
				w.seq    = SEQ_JUMP;
				w.target = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

	// weight register saturates to plus or minus one
	function automatic logic signed [16:0] clamp_weight(input logic [16:0] v);
		logic signed [16:0] s;
		s = $signed(v);
		if (s > WEIGHT_MAX) begin
			return WEIGHT_MAX;
		end else if (s < WEIGHT_MIN) begin
			return WEIGHT_MIN;
		end
		return s;
	endfunction

	// mix register saturates to one
	function automatic logic [15:0] clamp_mix(input logic [15:0] v);
		return (v > MIX_ONE) ? MIX_ONE : v;
	endfunction

	// clamp a scaled envelope difference to plus or minus one in q1.31
	function automatic logic signed [32:0] clamp_q31(input logic signed [35:0] v);
		if (v > 36'(ONE_Q31)) begin
			return ONE_Q31;
		end else if (v < -36'(ONE_Q31)) begin
			return -ONE_Q31;
		end
		return v[32:0];
	endfunction

endpackage

`default_nettype wire

### hw/rtl/transient_shaper_top.sv
// ---------------------------------------------------------------------------
// transient_shaper_top
// dual-envelope transient shaper, sequenced by a small control program
// around one shared 33x33 multiplier
// ---------------------------------------------------------------------------
//
//  channel  handshake                 payload
//  in       in_valid / in_stall       sample_in, channel
//  out      out_valid / out_stall     sample_out
//  cfg      psel, penable, pready     paddr, pwrite, pwdata, prdata
//
// a shaped word walks every program step in order from accept to the result
// register, and the next word is then taken at the wait step;
// six of the steps feed the single multiplier in turn
// a word that passes through (shaping off, or a channel without state) skips
// from the difference step straight to the emit step
// reset clears envelopes, registers to defaults and the step counter to wait
// the next word is accepted while a result still sits in the output register;
// the last step holds until that register is free
// ---------------------------------------------------------------------------
`default_nettype none

`include "transient_shaper_top_macros.svh"

module transient_shaper_top #(
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [4:0]             paddr,
	input  wire logic [31:0]            pwdata,
	output logic      [31:0]            prdata,
	output logic                        pready,
	// input words
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [SAMPLE_BITS-1:0] sample_in,
	input  wire logic                   channel,
	// result words
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [SAMPLE_BITS-1:0]      sample_out
);

	localparam int DetShift = 32 - SAMPLE_BITS;
	localparam logic [SAMPLE_BITS-1:0] SMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [33:0] RLimit = 34'(1) << (SAMPLE_BITS - 1);

	// sequencer
	ts_pkg::step_t pc_q, pc_d;
	ts_pkg::ctrl_t ctrl;

	// configuration registers
	logic               enable_q;
	logic [23:0]        fc_q, sc_q;
	logic [24:0]        nf_q, ns_q;
	logic signed [16:0] atk_q, sus_q;
	logic [15:0]        mix_q;

	// item and datapath registers
	logic [SAMPLE_BITS-1:0] smp_q, mag_q;
	logic                   ch_q, byp_q;
	logic [CHANNELS-1:0][31:0] fenv_q, senv_q;
	logic signed [32:0]     dfast_q, dslow_q, t_q, b_q;
	logic signed [65:0]     p_q;
	logic signed [49:0]     acc_q;
	logic [31:0]            g30_q, geff_q;
	logic [SAMPLE_BITS-1:0] res_q;
	logic                   out_valid_q;

	// combinational
	logic                   wr_en, in_acc, out_free;
	logic [31:0]            fenv_rd, senv_rd, det;
	logic signed [32:0]     dd;
	logic signed [35:0]     d36, t36, b36;
	logic signed [32:0]     mul_a, mul_b;
	logic signed [65:0]     prod;
	logic signed [49:0]     gsum, gclamp;
	logic [47:0]            gesum;
	logic [63:0]            rsum;
	logic [33:0]            r34;
	logic [SAMPLE_BITS-1:0] shaped, res_d;

	assign ctrl = ts_pkg::ucode(pc_q);

	// configuration port
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			fc_q     <= ts_pkg::FAST_COEF_RESET;
			sc_q     <= ts_pkg::SLOW_COEF_RESET;
			nf_q     <= ts_pkg::FAST_NCOEF_RESET;
			ns_q     <= ts_pkg::SLOW_NCOEF_RESET;
			atk_q    <= '0;
			sus_q    <= '0;
			mix_q    <= '0;
		end else if (wr_en) begin
			case (paddr[4:2])
				ts_pkg::REG_ENABLE: begin
					enable_q <= pwdata[0];
				end
				ts_pkg::REG_FAST: begin
					fc_q <= pwdata[23:0];
					nf_q <= ts_pkg::ONE_Q24 - {1'b0, pwdata[23:0]};
				end
				ts_pkg::REG_SLOW: begin
					sc_q <= pwdata[23:0];
					ns_q <= ts_pkg::ONE_Q24 - {1'b0, pwdata[23:0]};
				end
				ts_pkg::REG_ATTACK: begin
					atk_q <= ts_pkg::clamp_weight(pwdata[16:0]);
				end
				ts_pkg::REG_SUSTAIN: begin
					sus_q <= ts_pkg::clamp_weight(pwdata[16:0]);
				end
				ts_pkg::REG_MIX: begin
					mix_q <= ts_pkg::clamp_mix(pwdata[15:0]);
				end
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[4:2])
			ts_pkg::REG_ENABLE:  prdata = {31'b0, enable_q};
			ts_pkg::REG_FAST:    prdata = {8'b0, fc_q};
			ts_pkg::REG_SLOW:    prdata = {8'b0, sc_q};
			ts_pkg::REG_ATTACK:  prdata = 32'(atk_q);
			ts_pkg::REG_SUSTAIN: prdata = 32'(sus_q);
			ts_pkg::REG_MIX:     prdata = {16'b0, mix_q};
			default:             prdata = 32'b0;
		endcase
	end

	// handshakes
	assign in_stall  = !ctrl.take;
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign sample_out = res_q;

	// step counter next value
	always_comb begin
		case (ctrl.seq)
			ts_pkg::SEQ_NEXT:   pc_d = pc_q + 4'd1;
			ts_pkg::SEQ_JUMP:   pc_d = ctrl.target;
			ts_pkg::SEQ_INPUT:  pc_d = in_acc ? pc_q + 4'd1 : pc_q;
			ts_pkg::SEQ_BYPASS: pc_d = byp_q ? ctrl.target : pc_q + 4'd1;
			ts_pkg::SEQ_OUTPUT: pc_d = out_free ? ctrl.target : pc_q;
			default:            pc_d = ts_pkg::STEP_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ts_pkg::STEP_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

	// latch the accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (in_acc) begin
			byp_q <= !enable_q || (int'(channel) >= CHANNELS);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_q <= sample_in;
			ch_q  <= channel;
			mag_q <= sample_in[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - sample_in) : sample_in;
		end
	end

	// envelope read for the current channel
	always_comb begin
		fenv_rd = '0;
		senv_rd = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (int'(ch_q) == c) begin
				fenv_rd = fenv_q[c];
				senv_rd = senv_q[c];
			end
		end
	end

	// detector in q1.31
	assign det = 32'(mag_q) << DetShift;

	// envelope update: env + floor((1 - a) * (det - env))
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fenv_q <= '0;
			senv_q <= '0;
		end else begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (ctrl.wr_fast && int'(ch_q) == c) begin
					fenv_q[c] <= fenv_rd + p_q[55:24];
				end
				if (ctrl.wr_slow && int'(ch_q) == c) begin
					senv_q[c] <= senv_rd + p_q[55:24];
				end
			end
		end
	end

	// transient and body from the envelope difference
	assign dd  = $signed({1'b0, fenv_rd}) - $signed({1'b0, senv_rd});
	assign d36 = 36'(dd);
	assign t36 = d36 <<< 3;
	assign b36 = 36'sd0 - (d36 <<< 2) - d36;

	// multiplier operand select
	always_comb begin
		case (ctrl.mul_sel)
			ts_pkg::MUL_FAST: begin
				mul_a = dfast_q;
				mul_b = $signed({8'b0, nf_q});
			end
			ts_pkg::MUL_SLOW: begin
				mul_a = dslow_q;
				mul_b = $signed({8'b0, ns_q});
			end
			ts_pkg::MUL_ATK: begin
				mul_a = t_q;
				mul_b = 33'(atk_q);
			end
			ts_pkg::MUL_SUS: begin
				mul_a = b_q;
				mul_b = 33'(sus_q);
			end
			ts_pkg::MUL_MIX: begin
				mul_a = $signed({1'b0, g30_q});
				mul_b = $signed({17'b0, mix_q});
			end
			ts_pkg::MUL_OUT: begin
				mul_a = $signed({1'b0, 32'(mag_q)});
				mul_b = $signed({1'b0, geff_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// gain sum clamped to 0..3, then taken to q2.30
	assign gsum = acc_q + $signed(p_q[49:0]);
	always_comb begin
		if (gsum < 50'sd0) begin
			gclamp = '0;
		end else if (gsum > ts_pkg::GAIN_MAX) begin
			gclamp = ts_pkg::GAIN_MAX;
		end else begin
			gclamp = gsum;
		end
	end

	// blend dry and gained paths into one effective gain
	assign gesum = 48'({ts_pkg::MIX_ONE - mix_q, 30'b0}) + p_q[47:0];

	// round half away from zero on the magnitude, saturate, restore sign
	assign rsum = p_q[63:0] + 64'h20000000;
	assign r34  = rsum[63:30];
	always_comb begin
		if (smp_q[SAMPLE_BITS-1]) begin
			shaped = (r34 >= RLimit) ? SMin : (SAMPLE_BITS'(0) - r34[SAMPLE_BITS-1:0]);
		end else begin
			shaped = (r34 >= RLimit) ? SMax : r34[SAMPLE_BITS-1:0];
		end
	end
	assign res_d = byp_q ? smp_q : shaped;

	// datapath registers
	always_ff @(posedge clk) begin
		if (ctrl.ld_diff) begin
			dfast_q <= $signed({1'b0, det}) - $signed({1'b0, fenv_rd});
			dslow_q <= $signed({1'b0, det}) - $signed({1'b0, senv_rd});
		end
		if (ctrl.mul_sel != ts_pkg::MUL_NONE) begin
			p_q <= prod;
		end
		if (ctrl.ld_tb) begin
			t_q <= ts_pkg::clamp_q31(t36);
			b_q <= ts_pkg::clamp_q31(b36);
		end
		if (ctrl.ld_acc) begin
			acc_q <= ts_pkg::ONE_Q46 + $signed(p_q[49:0]);
		end
		if (ctrl.ld_gain) begin
			g30_q <= gclamp[47:16];
		end
		if (ctrl.ld_geff) begin
			geff_q <= gesum[46:15];
		end
		if (ctrl.emit && out_free) begin
			res_q <= res_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// checks
	`TS_ASSERT_NEXT(a_accept_starts, in_acc, pc_q == ts_pkg::STEP_DIFF, "accept did not start program")
	`TS_ASSERT_NEXT(a_bypass_skips, byp_q && pc_q == ts_pkg::STEP_DIFF, pc_q == ts_pkg::STEP_EMIT, "pass-through word entered shaping steps")
	`TS_ASSERT_NEXT(a_fast_env_hold, pc_q != ts_pkg::STEP_WFAST, $stable(fenv_q), "fast envelope changed outside its write step")
	`TS_ASSERT_NOW(a_pc_range, 1'b1, pc_q <= ts_pkg::STEP_EMIT, "step counter beyond program")

endmodule

`default_nettype wire
